// ===== rtl/multi_voice_tone_synth_top_defines.svh =====
// Assertion helpers used by the tone synth top module.
`ifndef MULTI_VOICE_TONE_SYNTH_TOP_DEFINES_SVH
`define MULTI_VOICE_TONE_SYNTH_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MVTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MVTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mvts_pkg.sv =====
package mvts_pkg;

	localparam int MAX_VOICES      = 4;
	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 10;

	localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
	localparam int QUARTER      = 1 << QUARTER_BITS;

	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 32;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 3;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CONTRIB_W  = 22;
	localparam int MIX_W      = 27;
	localparam int PROD_W     = 30;
	localparam int TAB_W      = 15;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_COUNT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP0 = 3'd2;
	localparam int NUM_STEP_REGS = 4;

	// Waveform modes
	localparam logic [MODE_W-1:0] MODE_SINE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SQUARE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HARM    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SILENCE = 2'd3;

	// Q16 amplitude coefficients, square level in Q8 sample units
	localparam int SINE_COEF = 9830;
	localparam int HARM_C1   = 6554;
	localparam int HARM_C2   = 3277;
	localparam int HARM_C3   = 1966;
	localparam int HARM_C4   = 983;
	localparam int SQUARE_Q8 = 838835;

	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	localparam longint ONE_Q30 = 64'sd1073741824;

	typedef logic [PHASE_BITS-1:0]        phase_t;
	typedef logic [STEP_W-1:0]            step_t;
	typedef logic signed [SAMPLE_W-1:0]   sample_t;
	typedef logic signed [CONTRIB_W-1:0]  contrib_t;
	typedef logic [TAB_W-1:0]             qtab_t [QUARTER+1];

	typedef struct packed {
		sample_t sample;
		logic    clip;
	} mix_res_t;

	// 32767 * sin(pi/2 * x), x in Q30 on [0, 1]
	function automatic int quarter_sine(longint x);
		longint x2;
		longint t;
		longint s;
		longint v;
		x2 = x * x / ONE_Q30;
		t  = 64'sd172272;
		t  = -64'sd5026994 + t * x2 / ONE_Q30;
		t  = 64'sd85569306 + t * x2 / ONE_Q30;
		t  = -64'sd693598668 + t * x2 / ONE_Q30;
		t  = 64'sd1686629713 + t * x2 / ONE_Q30;
		s  = x * t / ONE_Q30;
		if (s < 0) s = 0;
		v = (s * 32767 + ONE_Q30 / 2) / ONE_Q30;
		if (v > 32767) v = 32767;
		return int'(v);
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int p = 0; p <= QUARTER; p++) begin
			tab[p] = TAB_W'(quarter_sine(longint'(p) << (30 - QUARTER_BITS)));
		end
		return tab;
	endfunction

	localparam qtab_t QSIN_TAB = build_qtab();

	// Full-wave sine from the quarter table, indexed by the top phase bits
	function automatic sample_t sine_lookup(phase_t ph);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [1:0]                 quad;
		logic [QUARTER_BITS-1:0]    r;
		logic [QUARTER_BITS:0]      pos;
		sample_t                    mag;
		idx  = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		r    = idx[QUARTER_BITS-1:0];
		pos  = quad[0] ? ((QUARTER_BITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
		mag  = sample_t'({1'b0, QSIN_TAB[pos]});
		return quad[1] ? -mag : mag;
	endfunction

endpackage

// ===== rtl/multi_voice_tone_synth_top.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    restart, existing_sample
// output    out_valid/out_ready  mixed_sample, clipped
// config    cfg_we               cfg_addr, cfg_wdata
//
// One sample a cycle sustained while out_ready stays high; three register
// stages (phase capture, per-voice table lookup and scaling, mix and saturate).
// Each stage holds its item only while the stage after it is full and stalled,
// so two more items enter while a result waits. Reset clears the phases and
// loads mode sine, one voice, all steps zero.
`include "multi_voice_tone_synth_top_defines.svh"

module multi_voice_tone_synth_top
	import mvts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	input  sample_t               existing_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sample_t               mixed_sample,
	output logic                  clipped
);

	logic [MODE_W-1:0]  mode_q;
	logic [COUNT_W-1:0] count_q;
	step_t              step_q [MAX_VOICES];
	phase_t             phase_q [MAX_VOICES];

	logic     valid_s1, valid_s2, out_valid_q;
	logic     rdy_s1, rdy_s2;
	phase_t   phase_s1 [MAX_VOICES];
	sample_t  existing_s1, existing_s2;
	contrib_t contrib_c [MAX_VOICES];
	contrib_t contrib_s2 [MAX_VOICES];
	logic     active [MAX_VOICES];
	mix_res_t mix_c;
	sample_t  mixed_q;
	logic     clipped_q;
	logic     in_xfer;

	assign rdy_s2   = !out_valid_q || out_ready;
	assign rdy_s1   = !valid_s2 || rdy_s2;
	assign in_ready = !valid_s1 || rdy_s1;
	assign in_xfer  = in_valid && in_ready;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SINE;
			count_q <= COUNT_W'(1);
			for (int v = 0; v < MAX_VOICES; v++) step_q[v] <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == REG_MODE) mode_q <= cfg_wdata[MODE_W-1:0];
			if (cfg_addr == REG_COUNT) count_q <= cfg_wdata[COUNT_W-1:0];
			for (int v = 0; v < MAX_VOICES; v++) begin
				if (v < NUM_STEP_REGS && cfg_addr == REG_STEP0 + CFG_ADDR_W'(v))
					step_q[v] <= cfg_wdata[STEP_W-1:0];
			end
		end
	end

	// Phase accumulators: advance once per input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < MAX_VOICES; v++) phase_q[v] <= '0;
		end else if (in_xfer) begin
			for (int v = 0; v < MAX_VOICES; v++)
				phase_q[v] <= (restart ? '0 : phase_q[v]) + PHASE_BITS'(step_q[v]);
		end
	end

	// Stage 1: phases in use for this sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ready) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			existing_s1 <= existing_sample;
			for (int v = 0; v < MAX_VOICES; v++)
				phase_s1[v] <= restart ? '0 : phase_q[v];
		end
	end

	for (genvar g = 0; g < MAX_VOICES; g++) begin : g_voice
		// count above MAX_VOICES still enables every voice
		assign active[g] = (COUNT_W+8)'(g) < (COUNT_W+8)'(count_q);
		mvts_voice u_voice (
			.mode    (mode_q),
			.active  (active[g]),
			.phase   (phase_s1[g]),
			.contrib (contrib_c[g])
		);
	end

	// Stage 2: per-voice contributions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (rdy_s1) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && valid_s1) begin
			existing_s2 <= existing_s1;
			for (int v = 0; v < MAX_VOICES; v++) contrib_s2[v] <= contrib_c[v];
		end
	end

	mvts_mix u_mix (
		.existing (existing_s2),
		.contrib  (contrib_s2),
		.res      (mix_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (rdy_s2) out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s2) begin
			mixed_q   <= mix_c.sample;
			clipped_q <= mix_c.clip;
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign clipped      = clipped_q;

	`MVTS_ASSERT_NOW(a_clip_saturates, clk, arst_n, out_valid && clipped,
		(mixed_sample == sample_t'(SAT_MAX) || mixed_sample == sample_t'(SAT_MIN)),
		"clip flag without saturated sample")
	`MVTS_ASSERT_NEXT(a_restart_zero, clk, arst_n, in_xfer && restart, phase_s1[0] == '0,
		"restart did not clear the phase")
	`MVTS_ASSERT_NEXT(a_xfer_fills_s1, clk, arst_n, in_xfer, valid_s1,
		"accepted item lost in stage 1")

endmodule

// ===== rtl/mvts_voice.sv =====
module mvts_voice
	import mvts_pkg::*;
(
	input  logic [MODE_W-1:0] mode,
	input  logic              active,
	input  phase_t            phase,
	output contrib_t          contrib
);

	phase_t                   ph2, ph3, ph4;
	logic signed [PROD_W-1:0] e1, e2, e3, e4;
	logic signed [PROD_W-1:0] sine_prod, harm_sum;

	assign ph2 = phase << 1;
	assign ph3 = phase + (phase << 1);
	assign ph4 = phase << 2;

	assign e1 = PROD_W'(sine_lookup(phase));
	assign e2 = PROD_W'(sine_lookup(ph2));
	assign e3 = PROD_W'(sine_lookup(ph3));
	assign e4 = PROD_W'(sine_lookup(ph4));

	assign sine_prod = e1 * PROD_W'(SINE_COEF);
	assign harm_sum  = e1 * PROD_W'(HARM_C1) + e2 * PROD_W'(HARM_C2)
	                 + e3 * PROD_W'(HARM_C3) + e4 * PROD_W'(HARM_C4);

	always_comb begin
		contrib = '0;
		if (active) begin
			case (mode)
				MODE_SINE:   contrib = CONTRIB_W'(sine_prod / 256);
				MODE_SQUARE: contrib = phase[PHASE_BITS-1] ? -CONTRIB_W'(SQUARE_Q8)
				                                           : CONTRIB_W'(SQUARE_Q8);
				MODE_HARM:   contrib = CONTRIB_W'(harm_sum / 256);
				default:     contrib = '0;
			endcase
		end
	end

endmodule

// ===== rtl/mvts_mix.sv =====
module mvts_mix
	import mvts_pkg::*;
(
	input  sample_t  existing,
	input  contrib_t contrib [MAX_VOICES],
	output mix_res_t res
);

	logic signed [MIX_W-1:0] acc;
	logic signed [MIX_W-1:0] y;

	always_comb begin
		acc = {{(MIX_W-SAMPLE_W-8){existing[SAMPLE_W-1]}}, existing, 8'd0};
		for (int v = 0; v < MAX_VOICES; v++) begin
			acc = acc + MIX_W'(contrib[v]);
		end
		// truncate toward zero, then saturate
		y = MIX_W'(acc / 256);
		if (y > MIX_W'(SAT_MAX)) begin
			res.sample = sample_t'(SAT_MAX);
			res.clip   = 1'b1;
		end else if (y < MIX_W'(SAT_MIN)) begin
			res.sample = sample_t'(SAT_MIN);
			res.clip   = 1'b1;
		end else begin
			res.sample = sample_t'(y);
			res.clip   = 1'b0;
		end
	end

endmodule

// ===== bench/multi_voice_tone_synth_top_tb.sv =====
`timescale 1ns / 1ps

module multi_voice_tone_synth_top_tb;
	import mvts_pkg::*;

	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int LONG_HOLD       = 64;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int N_DIR           = 33;

	// indexes with no register behind them
	localparam logic [CFG_ADDR_W-1:0] REG_NONE_LO = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_NONE_HI = 3'd7;

	localparam logic [MODE_W-1:0] MODE_ORDER [4] = '{MODE_SINE, MODE_SQUARE, MODE_HARM,
		MODE_SILENCE};
	localparam int VOICES_BY_PHASE [N_PHASES] = '{1, 4, 7, 0, 2, 4, 5, 3};

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_ADDR_W-1:0]   addr;
		logic [CFG_DATA_W-1:0]   data;
		bit                      restart;
		sample_t                 sample;
		bit                      typed;
		sample_t                 want_sample;
		bit                      want_clip;
	} dir_row_t;

	// kind, addr, data, restart, sample, typed, expected sample, expected clip
	dir_row_t dir_rows [N_DIR] = '{
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h8000, 1'b1, 16'h8000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		'{ROW_CFG, REG_MODE, MODE_SQUARE, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_STEP0, 32'h8000_0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		// square high half pushes past full scale, low half past negative full scale
		'{ROW_ITEM, REG_MODE, '0, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h8000, 1'b1, 16'h8000, 1'b1},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		// count above the voice limit, upper bits set
		'{ROW_CFG, REG_COUNT, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_STEP0 + 3'd1, 32'h4000_0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_STEP0 + 3'd2, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_STEP0 + 3'd3, 32'h0123_4567, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h4000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'hC000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_MODE, MODE_HARM, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h0100, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_MODE, MODE_SILENCE, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h1234, 1'b1, 16'h1234, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b1, 16'h8000, 1'b1, 16'h8000, 1'b0},
		// mode bits low, everything above set
		'{ROW_CFG, REG_MODE, 32'hFFFF_FFFC, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_COUNT, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
		'{ROW_CFG, REG_NONE_LO, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_NONE_HI, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG, REG_COUNT, 32'h0000_0004, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, REG_MODE, '0, 1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic                  restart;
	sample_t               existing_sample;
	logic                  out_valid;
	logic                  out_ready;
	sample_t               mixed_sample;
	logic                  clipped;

	// shadow of the block's registers and voice phases
	bit [MODE_W-1:0]  wave_sel;
	bit [COUNT_W-1:0] voice_cnt;
	phase_t           voice_inc [MAX_VOICES];
	phase_t           tone_phase [MAX_VOICES];
	int               sin_tab [1 << SINE_TABLE_BITS];

	mix_res_t pending_mix [$];
	bit       typed_now;
	mix_res_t typed_mix;
	bit       src_idle_on;
	bit       sink_idle_on;
	bit       hold_req;
	int       n_fail;
	int       stuck_cycles;

	multi_voice_tone_synth_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.restart         (restart),
		.existing_sample (existing_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mixed_sample    (mixed_sample),
		.clipped         (clipped)
	);

	always #6 clk = ~clk;

	// full-wave table: odd polynomial on the first quadrant, mirrored
	initial begin : sine_rom
		int unsigned quad;
		int unsigned rem;
		int unsigned pos;
		longint x;
		longint sq;
		longint t;
		longint s;
		longint v;
		for (int k = 0; k < (1 << SINE_TABLE_BITS); k++) begin
			quad = (k >> QUARTER_BITS) & 3;
			rem  = k & (QUARTER - 1);
			pos  = quad[0] ? QUARTER - rem : rem;
			x    = longint'(pos) << (30 - QUARTER_BITS);
			sq   = x * x / ONE_Q30;
			t    = 172272;
			t    = -5026994 + t * sq / ONE_Q30;
			t    = 85569306 + t * sq / ONE_Q30;
			t    = -693598668 + t * sq / ONE_Q30;
			t    = 1686629713 + t * sq / ONE_Q30;
			s    = x * t / ONE_Q30;
			if (s < 0) s = 0;
			v = (s * 32767 + ONE_Q30 / 2) / ONE_Q30;
			if (v > 32767) v = 32767;
			sin_tab[k] = (quad >= 2) ? -int'(v) : int'(v);
		end
	end

	function automatic int sin_at(phase_t ph);
		return sin_tab[ph[PHASE_BITS-1 -: SINE_TABLE_BITS]];
	endfunction

	// one mixed sample from the current phases, then advance every voice
	function automatic mix_res_t synth_sample(bit clear_ph, sample_t existing);
		mix_res_t res;
		longint   acc;
		longint   y;
		int       n;
		phase_t   p;
		if (clear_ph) begin
			foreach (tone_phase[v]) tone_phase[v] = '0;
		end
		n   = (voice_cnt > MAX_VOICES) ? MAX_VOICES : voice_cnt;
		acc = longint'(existing) * 256;
		for (int v = 0; v < n; v++) begin
			p = tone_phase[v];
			case (wave_sel)
			MODE_SINE:   acc += longint'(sin_at(p)) * SINE_COEF / 256;
			MODE_SQUARE: acc += p[PHASE_BITS-1] ? -longint'(SQUARE_Q8) : longint'(SQUARE_Q8);
			MODE_HARM:   acc += (longint'(sin_at(p)) * HARM_C1
					+ longint'(sin_at(p * 32'd2)) * HARM_C2
					+ longint'(sin_at(p * 32'd3)) * HARM_C3
					+ longint'(sin_at(p * 32'd4)) * HARM_C4) / 256;
			default: ;
			endcase
		end
		foreach (tone_phase[v]) tone_phase[v] = tone_phase[v] + voice_inc[v];
		y        = acc / 256;
		res.clip = 1'b0;
		if (y > SAT_MAX) begin
			y        = SAT_MAX;
			res.clip = 1'b1;
		end
		if (y < SAT_MIN) begin
			y        = SAT_MIN;
			res.clip = 1'b1;
		end
		res.sample = SAMPLE_W'(y);
		return res;
	endfunction

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
		REG_MODE:                 wave_sel = val[MODE_W-1:0];
		REG_COUNT:                voice_cnt = val[COUNT_W-1:0];
		REG_NONE_LO, REG_NONE_HI: ;
		default:                  voice_inc[idx - REG_STEP0] = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// returns right after the accepting edge, valid still high
	task automatic offer_item(bit rs, sample_t s, bit typed, sample_t want_s, bit want_c);
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		restart         <= rs;
		existing_sample <= s;
		in_valid        <= 1'b1;
		typed_now        = typed;
		typed_mix        = '{want_s, want_c};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic hold_input_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] reg_val;
		sample_t               s_val;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_addr        = '0;
		cfg_wdata       = '0;
		in_valid        = 1'b0;
		restart         = 1'b0;
		existing_sample = '0;
		wave_sel        = MODE_SINE;
		voice_cnt       = 1;
		foreach (voice_inc[v]) begin
			voice_inc[v]  = '0;
			tone_phase[v] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				hold_input_until_drained();
				write_reg(dir_rows[k].addr, dir_rows[k].data);
			end else begin
				offer_item(dir_rows[k].restart, dir_rows[k].sample, dir_rows[k].typed,
					dir_rows[k].want_sample, dir_rows[k].want_clip);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			hold_input_until_drained();
			reg_val = $urandom;
			reg_val[MODE_W-1:0] = MODE_ORDER[(ph + ph / 4) % 4];
			write_reg(REG_MODE, reg_val);
			reg_val = $urandom;
			reg_val[COUNT_W-1:0] = COUNT_W'(VOICES_BY_PHASE[ph]);
			write_reg(REG_COUNT, reg_val);
			for (int v = 0; v < NUM_STEP_REGS; v++) begin
				case ($urandom_range(0, 5))
				0:       reg_val = '0;
				1:       reg_val = '1;
				2:       reg_val = 32'h8000_0000;
				5:       reg_val = $urandom;
				default: reg_val = $urandom_range(1, 32'h00FF_FFFF);
				endcase
				write_reg(CFG_ADDR_W'(REG_STEP0 + v), reg_val);
			end
			src_idle_on  = (ph % 3 != 1) && ph != N_PHASES - 1;
			sink_idle_on = (ph % 3 != 2) && ph != N_PHASES - 1;
			// keep offering while the output side holds off
			if (ph == 2) begin
				src_idle_on = 1'b0;
				hold_req    = 1'b1;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 4 && k == ITEMS_PER_PHASE / 2) hold_input_until_drained();
				case ($urandom_range(0, 3))
				0:       s_val = sample_t'($urandom);
				1:       s_val = sample_t'(SAT_MAX - int'($urandom_range(0, 6000)));
				2:       s_val = sample_t'(SAT_MIN + int'($urandom_range(0, 6000)));
				default: s_val = sample_t'(int'($urandom_range(0, 4000)) - 2000);
				endcase
				offer_item($urandom_range(0, 15) == 0, s_val, 1'b0, '0, 1'b0);
			end
		end

		hold_input_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_fail == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		mix_res_t want;
		if (arst_n && in_valid && in_ready) begin
			want = synth_sample(restart, existing_sample);
			if (typed_now) want = typed_mix;
			pending_mix.push_back(want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_mix.size() == 0) begin
				$error("result transfer with nothing pending: mixed_sample %0d", mixed_sample);
				n_fail++;
			end else begin
				want = pending_mix.pop_front();
				if (mixed_sample !== want.sample) begin
					$error("mixed_sample: expected %0d, got %0d", want.sample, mixed_sample);
					n_fail++;
				end
				if (clipped !== want.clip) begin
					$error("clipped: expected %0d, got %0d", want.clip, clipped);
					n_fail++;
				end
			end
		end
	end

	// drop the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
		else stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
